[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file for its checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tgd_pkg.sv]
// Shared types, constants and register codes of the threshold gain distortion core.
package tgd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int GAIN_W          = 16;
  localparam int THR_W           = 15;
  localparam int COEF_W          = 31;
  localparam int NSTAGES         = 7;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd4096;
  localparam logic [GAIN_W-1:0] MIX_FULL   = 16'd32768;

  localparam logic [GAIN_W-1:0] PRE_AMP_RST   = 16'd410;
  localparam logic [GAIN_W-1:0] WET_MIX_RST   = 16'd0;
  localparam logic [GAIN_W-1:0] OUT_GAIN_RST  = 16'd4096;
  localparam logic [GAIN_W-1:0] LOW_GAIN_RST  = 16'd12288;
  localparam logic [GAIN_W-1:0] HIGH_GAIN_RST = 16'd410;
  localparam logic [THR_W-1:0]  NOISE_THR_RST = 15'd3277;
  localparam logic [THR_W-1:0]  LOWER_THR_RST = 15'd16384;
  localparam logic [THR_W-1:0]  UPPER_THR_RST = 15'd26214;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_AMP   = 3'd0,
    REG_WET_MIX   = 3'd1,
    REG_OUT_GAIN  = 3'd2,
    REG_LOW_GAIN  = 3'd3,
    REG_HIGH_GAIN = 3'd4,
    REG_NOISE_THR = 3'd5,
    REG_LOWER_THR = 3'd6,
    REG_UPPER_THR = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] pre_amp_gain;
    logic [GAIN_W-1:0] wet_mix;
    logic [GAIN_W-1:0] output_gain;
    logic [GAIN_W-1:0] low_band_gain;
    logic [GAIN_W-1:0] high_band_gain;
    logic [THR_W-1:0]  noise_threshold;
    logic [THR_W-1:0]  lower_threshold;
    logic [THR_W-1:0]  upper_threshold;
  } cfg_t;

  // Load enables, one per pipeline register, front to back.
  typedef struct packed {
    logic mag;
    logic gain;
    logic coef;
    logic acc;
    logic rnd;
    logic part;
    logic res;
  } stage_en_t;

endpackage

[rtl/tgd_in_if.sv]
// Input sample channel: valid/ready handshake with one signed sample per beat.
interface tgd_in_if
  import tgd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

[rtl/tgd_out_if.sv]
// Result channel: valid/ready handshake with the saturated sample and its clip flag.
interface tgd_out_if
  import tgd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

[rtl/tgd_ctrl.sv]
// Valid-bit pipeline and per-stage load enables with bubble collapsing.
module tgd_ctrl
  import tgd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output logic      out_valid,
  output stage_en_t en
);

  logic [NSTAGES:1] v;
  logic [NSTAGES:1] v_next;
  logic [NSTAGES:1] e;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    e[NSTAGES] = !v[NSTAGES] || out_ready;
    for (int i = NSTAGES - 1; i >= 1; i--) begin
      e[i] = !v[i] || e[i+1];
    end
  end

  always_comb begin
    v_next[1] = e[1] ? in_valid : v[1];
    for (int i = 2; i <= NSTAGES; i++) begin
      v_next[i] = e[i] ? v[i-1] : v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  assign in_ready  = e[1];
  assign out_valid = v[NSTAGES];

  assign en.mag  = e[1];
  assign en.gain = e[2];
  assign en.coef = e[3];
  assign en.acc  = e[4];
  assign en.rnd  = e[5];
  assign en.part = e[6];
  assign en.res  = e[7];

endmodule

[rtl/tgd_gain.sv]
// Pre-amp magnitude, threshold gain selection and blended coefficient (stages 1-3).
module tgd_gain
  import tgd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
  input  logic                          clk,
  input  stage_en_t                     en,
  input  cfg_t                          cfg,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] s3,
  output logic [COEF_W-1:0]             k3
);

  localparam int MAG_W = SAMPLE_BITS + GAIN_W;
  localparam int UP    = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;
  localparam int DN    = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
  localparam int CMP_W = (MAG_W > 32) ? MAG_W : 32;

  logic [SAMPLE_BITS-1:0]        mag_abs;
  logic [MAG_W-1:0]              mag_next;
  logic [MAG_W-1:0]              mag1;
  logic signed [SAMPLE_BITS-1:0] s1;
  logic [CMP_W-1:0]              mag_c;
  logic [CMP_W-1:0]              tn;
  logic [CMP_W-1:0]              tl;
  logic [CMP_W-1:0]              tu;
  logic [GAIN_W-1:0]             g_next;
  logic [GAIN_W-1:0]             g2;
  logic signed [SAMPLE_BITS-1:0] s2;
  logic [GAIN_W-1:0]             m;
  logic [27:0]                   dry;
  logic [31:0]                   k_sum;

  // Stage 1: |s| * pre-amp, full precision
  assign mag_abs  = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
  assign mag_next = MAG_W'(mag_abs) * MAG_W'(cfg.pre_amp_gain);

  always_ff @(posedge clk) begin
    if (en.mag) begin
      s1   <= sample;
      mag1 <= mag_next;
    end
  end

  // Stage 2: align magnitude and thresholds to one scale, then pick the gain
  assign mag_c = CMP_W'(mag1) << DN;
  assign tn    = CMP_W'({cfg.noise_threshold, 12'b0}) << UP;
  assign tl    = CMP_W'({cfg.lower_threshold, 12'b0}) << UP;
  assign tu    = CMP_W'({cfg.upper_threshold, 12'b0}) << UP;

  always_comb begin
    if (mag_c < tl && mag_c > tn) begin
      g_next = cfg.low_band_gain;
    end else if (mag_c > tu) begin
      g_next = cfg.high_band_gain;
    end else begin
      g_next = UNITY_GAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (en.gain) begin
      s2 <= s1;
      g2 <= g_next;
    end
  end

  // Stage 3: coefficient g*m + unity*(full - m), mix clamped to all wet
  assign m     = (cfg.wet_mix > MIX_FULL) ? MIX_FULL : cfg.wet_mix;
  assign dry   = {MIX_FULL - m, 12'b0};
  assign k_sum = 32'(g2) * 32'(m) + 32'(dry);

  always_ff @(posedge clk) begin
    if (en.coef) begin
      s3 <= s2;
      k3 <= k_sum[COEF_W-1:0];
    end
  end

endmodule

[rtl/tgd_mix.sv]
// Sample times coefficient and first rounding to Q.12 (stages 4-5).
module tgd_mix
  import tgd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
  input  logic                           clk,
  input  stage_en_t                      en,
  input  logic signed [SAMPLE_BITS-1:0]  s3,
  input  logic [COEF_W-1:0]              k3,
  output logic signed [SAMPLE_BITS+16:0] b5
);

  localparam int ACC_W = SAMPLE_BITS + COEF_W;
  localparam logic [ACC_W:0] HALF15 = {{(ACC_W - 14){1'b0}}, 1'b1, 14'b0};

  logic signed [ACC_W:0]   prod;
  logic signed [ACC_W-1:0] acc4;
  logic [ACC_W:0]          rnd;

  assign prod = s3 * $signed({1'b0, k3});

  always_ff @(posedge clk) begin
    if (en.acc) begin
      acc4 <= prod[ACC_W-1:0];
    end
  end

  // Round half up, then drop 15 fraction bits
  assign rnd = {acc4[ACC_W-1], acc4} + HALF15;

  always_ff @(posedge clk) begin
    if (en.rnd) begin
      b5 <= rnd[ACC_W:15];
    end
  end

endmodule

[rtl/tgd_scale.sv]
// Output gain as two partial products, final rounding and saturation (stages 6-7).
module tgd_scale
  import tgd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
  input  logic                           clk,
  input  stage_en_t                      en,
  input  logic [GAIN_W-1:0]              output_gain,
  input  logic signed [SAMPLE_BITS+16:0] b5,
  output logic signed [SAMPLE_BITS-1:0]  sample_out,
  output logic                           clipped
);

  localparam int BH_W  = SAMPLE_BITS - 7;
  localparam int PH_W  = BH_W + GAIN_W + 1;
  localparam int PL_W  = 24 + GAIN_W;
  localparam int SUM_W = SAMPLE_BITS + 35;
  localparam int Y_W   = SUM_W - 24;
  localparam logic [SUM_W-1:0] HALF24 = {{(SUM_W - 24){1'b0}}, 1'b1, 23'b0};
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  logic signed [BH_W-1:0]         bh;
  logic [23:0]                    bl;
  logic signed [PH_W-1:0]         ph_next;
  logic [PL_W-1:0]                pl_next;
  logic signed [PH_W-1:0]         ph6;
  logic [PL_W-1:0]                pl6;
  logic [SUM_W-1:0]               sum;
  logic [Y_W-1:0]                 yv;
  logic [Y_W-SAMPLE_BITS:0]       top_bits;
  logic                           ovf;
  logic [SAMPLE_BITS-1:0]         y_sat;

  // Stage 6: split b into a signed upper part and a 24-bit lower part
  assign bh      = b5[SAMPLE_BITS+16:24];
  assign bl      = b5[23:0];
  assign ph_next = bh * $signed({1'b0, output_gain});
  assign pl_next = PL_W'(bl) * PL_W'(output_gain);

  always_ff @(posedge clk) begin
    if (en.part) begin
      ph6 <= ph_next;
      pl6 <= pl_next;
    end
  end

  // Stage 7: recombine, round half up, drop 24 bits, clamp
  assign sum      = {ph6[PH_W-1], ph6, 24'b0} + {{(SUM_W - PL_W){1'b0}}, pl6} + HALF24;
  assign yv       = sum[SUM_W-1:24];
  assign top_bits = yv[Y_W-1:SAMPLE_BITS-1];
  assign ovf      = (|top_bits) && !(&top_bits);
  assign y_sat    = ovf ? (yv[Y_W-1] ? SAT_MIN : SAT_MAX) : yv[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en.res) begin
      sample_out <= y_sat;
      clipped    <= ovf;
    end
  end

endmodule

[rtl/threshold_gain_distortion_core.sv]
// Top level of the threshold gain distortion core: registers, pipeline and checks.
//
//   Channel    Role     Beat payload               Handshake
//   feed       sink     sample_in                  valid/ready
//   result     source   sample_out, clipped        valid/ready
//   cfg        write    cfg_index, cfg_data        cfg_we, no wait
//
// Seven register stages: magnitude, gain pick, coefficient, product, round,
// partial products, output. One beat a cycle is taken for as long as the
// result side keeps up.
// A stalled result holds only the stages behind it that are full; empty stages
// still fill, so the input keeps taking beats until the pipeline is full.
// rst is synchronous; it clears the valid bits and loads the configuration registers with their reset values.
`include "assert_macros.svh"

module threshold_gain_distortion_core
  import tgd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tgd_in_if.sink                feed,
  tgd_out_if.source             result
);

  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  cfg_t                          cfg;
  stage_en_t                     en;
  logic signed [SAMPLE_BITS-1:0] s3;
  logic [COEF_W-1:0]             k3;
  logic signed [SAMPLE_BITS+16:0] b5;

  // Configuration registers: write by index, narrow registers keep the low bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pre_amp_gain    <= PRE_AMP_RST;
      cfg.wet_mix         <= WET_MIX_RST;
      cfg.output_gain     <= OUT_GAIN_RST;
      cfg.low_band_gain   <= LOW_GAIN_RST;
      cfg.high_band_gain  <= HIGH_GAIN_RST;
      cfg.noise_threshold <= NOISE_THR_RST;
      cfg.lower_threshold <= LOWER_THR_RST;
      cfg.upper_threshold <= UPPER_THR_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PRE_AMP:   cfg.pre_amp_gain    <= cfg_data;
        REG_WET_MIX:   cfg.wet_mix         <= cfg_data;
        REG_OUT_GAIN:  cfg.output_gain     <= cfg_data;
        REG_LOW_GAIN:  cfg.low_band_gain   <= cfg_data;
        REG_HIGH_GAIN: cfg.high_band_gain  <= cfg_data;
        REG_NOISE_THR: cfg.noise_threshold <= cfg_data[THR_W-1:0];
        REG_LOWER_THR: cfg.lower_threshold <= cfg_data[THR_W-1:0];
        REG_UPPER_THR: cfg.upper_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits and load enables for every stage
  tgd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (feed.valid),
    .out_ready (result.ready),
    .in_ready  (feed.ready),
    .out_valid (result.valid),
    .en        (en)
  );

  // Stages 1-3: magnitude, gain band and mix coefficient
  tgd_gain #(.SAMPLE_BITS(SAMPLE_BITS)) u_gain (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .sample (feed.sample_in),
    .s3     (s3),
    .k3     (k3)
  );

  // Stages 4-5: blended product and rounding to the Q.12 scale
  tgd_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_mix (
    .clk (clk),
    .en  (en),
    .s3  (s3),
    .k3  (k3),
    .b5  (b5)
  );

  // Stages 6-7: output gain, rounding and saturation into the result register
  tgd_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
    .clk         (clk),
    .en          (en),
    .output_gain (cfg.output_gain),
    .b5          (b5),
    .sample_out  (result.sample_out),
    .clipped     (result.clipped)
  );

  // A clipped result must sit on one of the two rails
  `ASSERT_IMPL(a_clip_on_rail, clk, rst, result.valid && result.clipped, result.sample_out == SAT_MAX || result.sample_out == SAT_MIN, "clipped result is not at a rail")

  // Input back-pressure only ever comes from a held result
  `ASSERT_IMPL(a_stall_source, clk, rst, !feed.ready, result.valid && !result.ready, "input stalled without a held result")

  // An empty output stage leaves the pipeline able to take a beat
  `ASSERT_IMPL(a_no_deadlock, clk, rst, !result.valid, feed.ready, "input not ready while the output stage is empty")

endmodule

[test/tb_top.sv]
// Self-checking testbench of the threshold gain distortion core.
`timescale 1ns / 1ps

module tb_top;
  import tgd_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int PIPE_DEPTH   = 7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 54;
  localparam int CHOKE_CYCLES = 80;

  // One predicted result beat.
  typedef struct packed {
    logic signed [SB-1:0] sample;
    logic                 clip;
  } shaped_t;

  // Holds a copy of the register file, works out the shaped sample for every
  // accepted input beat and compares result beats with the oldest prediction.
  class distortion_scoreboard;
    logic [GAIN_W-1:0] pre_amp, wet_mix, out_gain, low_gain, high_gain;
    logic [THR_W-1:0]  noise_thr, lower_thr, upper_thr;
    shaped_t           pending[$];
    int                errors;

    function new();
      pre_amp   = PRE_AMP_RST;
      wet_mix   = WET_MIX_RST;
      out_gain  = OUT_GAIN_RST;
      low_gain  = LOW_GAIN_RST;
      high_gain = HIGH_GAIN_RST;
      noise_thr = NOISE_THR_RST;
      lower_thr = LOWER_THR_RST;
      upper_thr = UPPER_THR_RST;
      errors    = 0;
    endfunction

    // Threshold registers keep only their low 15 bits.
    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PRE_AMP:   pre_amp   = val;
        REG_WET_MIX:   wet_mix   = val;
        REG_OUT_GAIN:  out_gain  = val;
        REG_LOW_GAIN:  low_gain  = val;
        REG_HIGH_GAIN: high_gain = val;
        REG_NOISE_THR: noise_thr = val[THR_W-1:0];
        REG_LOWER_THR: lower_thr = val[THR_W-1:0];
        REG_UPPER_THR: upper_thr = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function shaped_t shape(logic signed [SB-1:0] s);
      longint  sv, pa, mag, tn, tl, tu, g, m, coef, acc, b, og, y;
      longint  maxv, minv;
      shaped_t r;
      sv   = s;
      pa   = pre_amp;
      og   = out_gain;
      maxv = (longint'(1) <<< (SB - 1)) - 1;
      minv = -maxv - 1;
      mag  = (sv < 0 ? -sv : sv) * pa;
      tn   = longint'(noise_thr) * 4096;
      tl   = longint'(lower_thr) * 4096;
      tu   = longint'(upper_thr) * 4096;
      if (mag < tl && mag > tn) g = low_gain;
      else if (mag > tu)        g = high_gain;
      else                      g = UNITY_GAIN;
      m    = wet_mix > MIX_FULL ? MIX_FULL : wet_mix;
      coef = g * m + longint'(UNITY_GAIN) * (longint'(MIX_FULL) - m);
      acc  = sv * coef;
      // Round half up: add half an LSB, then floor with an arithmetic shift.
      b    = (acc + (longint'(1) <<< 14)) >>> 15;
      y    = (b * og + (longint'(1) <<< 23)) >>> 24;
      r.clip = 1'b0;
      if (y > maxv) begin
        y = maxv;
        r.clip = 1'b1;
      end else if (y < minv) begin
        y = minv;
        r.clip = 1'b1;
      end
      r.sample = y[SB-1:0];
      return r;
    endfunction

    function void note_sample(logic signed [SB-1:0] s);
      pending.push_back(shape(s));
    endfunction

    function void check_result(logic signed [SB-1:0] y, logic c);
      shaped_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, sample_out %0d clipped %0b", $time, y, c);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (y !== e.sample) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, e.sample, y);
        errors++;
      end
      if (c !== e.clip) begin
        $display("%0t: clipped expected %0b actual %0b", $time, e.clip, c);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tgd_in_if  #(.SAMPLE_BITS(SB)) feed_if ();
  tgd_out_if #(.SAMPLE_BITS(SB)) result_if ();

  threshold_gain_distortion_core #(.SAMPLE_BITS(SB)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .feed      (feed_if.sink),
    .result    (result_if.source)
  );

  distortion_scoreboard sb = new();

  bit idle_on    = 1'b1;  // random gaps and stalls allowed
  bit choke_req  = 1'b0;  // ask the receiver for one long hold-off
  int cycle_count = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Guard against a hung pipeline.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: stall in random bursts, or hold off for a long stretch on request
  // so that the pipeline fills and the feed backs up.
  initial begin
    int n;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke_req) begin
        result_if.ready <= 1'b0;
        repeat (CHOKE_CYCLES - 1) @(negedge clk);
        choke_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        result_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Check every result beat as it is taken.
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready)
      sb.check_result(result_if.sample_out, result_if.clipped);
  end

  // Offer one sample and hold it until the core takes the beat.
  task automatic send_sample(logic signed [SB-1:0] s);
    @(negedge clk);
    feed_if.valid     <= 1'b1;
    feed_if.sample_in <= s;
    do @(posedge clk); while (!feed_if.ready);
    sb.note_sample(s);
  endtask

  // Drop valid for a burst of random length.
  task automatic feed_gap();
    int n;
    n = $urandom_range(1, 14);
    @(negedge clk);
    feed_if.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_with_gaps(logic signed [SB-1:0] s);
    if (idle_on && $urandom_range(0, 4) == 0) feed_gap();
    send_sample(s);
  endtask

  // Lower valid and wait until every predicted beat has come back.
  task automatic drain();
    @(negedge clk);
    feed_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 8192));
      default: return 16'($urandom);
    endcase
  endfunction

  // Values above full scale must saturate to all wet.
  function automatic logic [15:0] pick_mix();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return MIX_FULL;
      2:       return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // Bit 15 is random so that the width mask gets exercised.
  function automatic logic [15:0] pick_thr();
    logic [14:0] t;
    case ($urandom_range(0, 4))
      0:       t = 15'd0;
      1:       t = 15'h7FFF;
      default: t = 15'($urandom);
    endcase
    return {1'($urandom), t};
  endfunction

  // Aim at a sample within 2 of the one whose magnitude sits on one of the three thresholds.
  function automatic logic signed [SB-1:0] near_edge();
    longint t, thr;
    case ($urandom_range(0, 2))
      0:       thr = sb.noise_thr;
      1:       thr = sb.lower_thr;
      default: thr = sb.upper_thr;
    endcase
    if (sb.pre_amp == 0) return SB'($urandom);
    t = thr * 4096 / longint'(sb.pre_amp) + longint'($urandom_range(0, 4)) - 2;
    if (t < 0) t = 0;
    if ($urandom_range(0, 1)) begin
      if (t > 32768) t = 32768;
      return SB'(-t);
    end
    if (t > 32767) t = 32767;
    return SB'(t);
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return near_edge();
    if (r == 4) begin
      case ($urandom_range(0, 4))
        0:       return 16'sh7FFF;
        1:       return 16'sh8000;
        2:       return 16'sd1;
        3:       return -16'sd1;
        default: return 16'sd0;
      endcase
    end
    return SB'($urandom);
  endfunction

  task automatic load_all(logic [15:0] pa, logic [15:0] wm, logic [15:0] og,
                          logic [15:0] lg, logic [15:0] hg, logic [15:0] nt,
                          logic [15:0] lt, logic [15:0] ut);
    write_reg(REG_PRE_AMP,   pa);
    write_reg(REG_WET_MIX,   wm);
    write_reg(REG_OUT_GAIN,  og);
    write_reg(REG_LOW_GAIN,  lg);
    write_reg(REG_HIGH_GAIN, hg);
    write_reg(REG_NOISE_THR, nt);
    write_reg(REG_LOWER_THR, lt);
    write_reg(REG_UPPER_THR, ut);
  endtask

  initial begin
    logic signed [SB-1:0] edge_set[$];
    feed_if.valid     = 1'b0;
    feed_if.sample_in = '0;
    cfg_we            = 1'b0;
    cfg_index         = REG_PRE_AMP;
    cfg_data          = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: dry path only, full-scale and zero samples.
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    drain();

    // Unity pre-amp and all wet: the magnitude is the sample itself, so probe
    // each threshold from both sides, plus the low band clipping at 3x.
    load_all(16'd4096, MIX_FULL, 16'd4096, 16'd12288, 16'd410,
             16'd3277, 16'd16384, 16'd26214);
    edge_set = '{16'sd3277, 16'sd3278, -16'sd3278, 16'sd16383, 16'sd16384,
                 -16'sd16383, 16'sd26214, 16'sd26215, -16'sd26215, 16'sh7FFF,
                 16'sh8000, 16'sd1, -16'sd1, 16'sd12000, -16'sd12000};
    foreach (edge_set[i]) send_with_gaps(edge_set[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      // The closing phases run with no gaps or stalls at all.
      if (p >= PHASES - 2) idle_on = 1'b0;
      case (p)
        0:       load_all(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        1:       load_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: load_all(pick_gain(), pick_mix(), pick_gain(), pick_gain(),
                          pick_gain(), pick_thr(), pick_thr(), pick_thr());
      endcase

      // Choke the result side while the feed keeps pushing beats.
      if (p == 2) choke_req = 1'b1;

      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (p == 2) send_sample(pick_sample());
        else send_with_gaps(pick_sample());
        // Pause the feed once until the pipeline has emptied.
        if (p == 3 && i == PHASE_BEATS / 2) drain();
      end
      drain();
    end

    // Allow any stray beat to surface before the verdict.
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/tgd_pkg.sv
rtl/tgd_in_if.sv
rtl/tgd_out_if.sv
rtl/tgd_ctrl.sv
rtl/tgd_gain.sv
rtl/tgd_mix.sv
rtl/tgd_scale.sv
rtl/threshold_gain_distortion_core.sv
test/tb_top.sv
